FILE: rtl/ffca_pkg.sv
// Shared constants, types and helpers for the first-fit arena allocator.
package ffca_pkg;

   localparam int ARENA_BYTES  = 4096;
   localparam int FREE_SLOTS   = 16;
   localparam int HEADER_BYTES = 4;

   localparam int ADDR_W = $clog2(ARENA_BYTES);
   localparam int SIZE_W = ADDR_W + 1;
   localparam int IDX_W  = $clog2(FREE_SLOTS);
   localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
   localparam int LEN_W  = 12;
   localparam int CAP_W  = 13;

   localparam logic [SIZE_W-1:0] SIZE_SAT = SIZE_W'(2 * ARENA_BYTES - 1);

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;
   localparam logic [1:0] STATUS_LIST_FULL = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_more;
      logic rsp_busy;
   } ctrl_sts_type;

   // Add two sizes, saturating at the largest size a hole may record
   function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
      logic [SIZE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SIZE_W] ? SIZE_SAT : s[SIZE_W-1:0];
   endfunction

endpackage

FILE: rtl/ffca_ctrl.sv
// Sequencing state machine: accept, size read, list scan, result hand-off.
module ffca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ffca_pkg::ctrl_sts_type sts,
   output ffca_pkg::ctrl_cmd_type cmd
);
   import ffca_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Decode the next state and the datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_more) begin
               cmd.step = 1'b1;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/ffca_dp.sv
// Datapath: free list, size store, bump head, capacity and result register.
module ffca_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ffca_pkg::ctrl_cmd_type cmd,
   output ffca_pkg::ctrl_sts_type sts,
   input  logic [0:0]            req_tuser,
   input  logic [23:0]           req_tdata,
   input  logic                  csr_valid,
   input  logic [15:0]           csr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [1:0]            rsp_tuser,
   output logic [15:0]           rsp_tdata
);
   import ffca_pkg::*;

   // Request capture
   logic              op_ff;
   logic [SIZE_W-1:0] need_ff;
   logic [ADDR_W-1:0] off_ff;
   logic [ADDR_W-1:0] hdr_ff;
   logic [CNT_W-1:0]  idx_ff;

   // Persistent state
   logic [SIZE_W-1:0] hole_start_ff [FREE_SLOTS];
   logic [SIZE_W-1:0] hole_size_ff  [FREE_SLOTS];
   logic [SIZE_W-1:0] hole_start_in [FREE_SLOTS];
   logic [SIZE_W-1:0] hole_size_in  [FREE_SLOTS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  bump_ff, bump_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [SIZE_W-1:0] size_mem [ARENA_BYTES];
   logic [SIZE_W-1:0] blk_size_ff;

   // Scan trail and results
   logic [SIZE_W-1:0] prev_start_ff, prev_size_ff;
   logic [1:0]        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_payload_ff, res_payload_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_payload_ff;

   // Commit controls
   logic              wr_en, rm_en, ins_en, mem_we;
   logic [IDX_W-1:0]  wr_idx;
   logic [SIZE_W-1:0] wr_start, wr_size;
   logic [SIZE_W-1:0] block;

   logic [SIZE_W-1:0] cur_start, cur_size, cap_eff;
   logic              idx_lt_count, bad_free, has_prev;
   logic [SIZE_W:0]   prev_end, free_end, bump_end;
   logic [SIZE_W-1:0] merge_size, merge2_size;
   logic [SIZE_W:0]   merge_end;

   assign cur_start    = hole_start_ff[idx_ff[IDX_W-1:0]];
   assign cur_size     = hole_size_ff[idx_ff[IDX_W-1:0]];
   assign idx_lt_count = idx_ff < count_ff;
   assign has_prev     = idx_ff != '0;
   assign cap_eff      = (cap_ff > CAP_W'(ARENA_BYTES)) ? SIZE_W'(ARENA_BYTES)
                                                        : SIZE_W'(cap_ff);
   assign bad_free     = (off_ff < ADDR_W'(HEADER_BYTES)) || ({1'b0, hdr_ff} >= cap_eff);

   // Tell the controller whether the scan goes on
   always_comb begin
      if (op_ff == OP_FREE) begin
         sts.scan_more = !bad_free && idx_lt_count && (cur_start < {1'b0, hdr_ff});
      end else begin
         sts.scan_more = idx_lt_count && (cur_size < need_ff);
      end
      sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   assign prev_end    = {1'b0, prev_start_ff} + {1'b0, prev_size_ff};
   assign free_end    = {2'b0, hdr_ff} + {1'b0, blk_size_ff};
   assign bump_end    = {1'b0, bump_ff} + {1'b0, need_ff};
   assign merge_size  = sat_add(prev_size_ff, blk_size_ff);
   assign merge_end   = {1'b0, prev_start_ff} + {1'b0, merge_size};
   assign merge2_size = sat_add(merge_size, cur_size);

   // Work out the list edit and the result of the current request
   always_comb begin
      wr_en          = 1'b0;
      rm_en          = 1'b0;
      ins_en         = 1'b0;
      mem_we         = 1'b0;
      wr_idx         = idx_ff[IDX_W-1:0];
      wr_start       = cur_start;
      wr_size        = cur_size;
      block          = bump_ff;
      count_in       = count_ff;
      bump_in        = bump_ff;
      res_status_in  = STATUS_OK;
      res_payload_in = '0;
      if (op_ff == OP_ALLOC) begin
         if (idx_lt_count) begin
            block = cur_start;
            if (cur_size == need_ff) begin
               rm_en    = 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_start = cur_start + need_ff;
               wr_size  = cur_size - need_ff;
            end
         end else if (bump_end > {1'b0, cap_eff}) begin
            res_status_in = STATUS_NO_SPACE;
         end else begin
            bump_in = bump_end[CAP_W-1:0];
         end
         if (res_status_in == STATUS_OK) begin
            mem_we         = !block[SIZE_W-1];
            res_payload_in = block[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
         end
      end else if (bad_free) begin
         res_status_in = STATUS_BAD_FREE;
      end else if (has_prev && prev_end == {2'b0, hdr_ff}) begin
         // Grow the hole in front, and swallow the one behind if they now touch
         wr_en    = 1'b1;
         wr_idx   = IDX_W'(idx_ff - 1'b1);
         wr_start = prev_start_ff;
         wr_size  = merge_size;
         if (idx_lt_count && merge_end == {1'b0, cur_start}) begin
            wr_size  = merge2_size;
            rm_en    = 1'b1;
            count_in = count_ff - 1'b1;
         end
      end else if (idx_lt_count && free_end == {1'b0, cur_start}) begin
         wr_en    = 1'b1;
         wr_start = {1'b0, hdr_ff};
         wr_size  = sat_add(cur_size, blk_size_ff);
      end else if (count_ff >= CNT_W'(FREE_SLOTS)) begin
         res_status_in = STATUS_LIST_FULL;
      end else begin
         wr_en    = 1'b1;
         ins_en   = 1'b1;
         wr_start = {1'b0, hdr_ff};
         wr_size  = blk_size_ff;
         count_in = count_ff + 1'b1;
      end
   end

   // Next value of each free-list entry: write, close a gap, or open one
   for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_slot
      always_comb begin
         hole_start_in[k] = hole_start_ff[k];
         hole_size_in[k]  = hole_size_ff[k];
         if (wr_en && wr_idx == IDX_W'(k)) begin
            hole_start_in[k] = wr_start;
            hole_size_in[k]  = wr_size;
         end else if (rm_en && idx_ff <= CNT_W'(k)) begin
            if (k < FREE_SLOTS - 1) begin
               hole_start_in[k] = hole_start_ff[(k + 1) % FREE_SLOTS];
               hole_size_in[k]  = hole_size_ff[(k + 1) % FREE_SLOTS];
            end
         end else if (ins_en && idx_ff < CNT_W'(k)) begin
            if (k > 0) begin
               hole_start_in[k] = hole_start_ff[(k + FREE_SLOTS - 1) % FREE_SLOTS];
               hole_size_in[k]  = hole_size_ff[(k + FREE_SLOTS - 1) % FREE_SLOTS];
            end
         end
      end
   end

   // Free-list entries: payload only
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hole_start_ff <= hole_start_in;
         hole_size_ff  <= hole_size_in;
      end
   end

   // Block size store: one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         size_mem[block[ADDR_W-1:0]] <= need_ff;
      end
      blk_size_ff <= size_mem[hdr_ff];
   end

   // Capture the request and walk the scan index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tuser[0];
         need_ff <= SIZE_W'(HEADER_BYTES + 1) + SIZE_W'(req_tdata[LEN_W-1:0]);
         off_ff  <= req_tdata[LEN_W+ADDR_W-1:LEN_W];
         hdr_ff  <= req_tdata[LEN_W+ADDR_W-1:LEN_W] - ADDR_W'(HEADER_BYTES);
         idx_ff  <= '0;
      end else if (cmd.step) begin
         idx_ff        <= idx_ff + 1'b1;
         prev_start_ff <= cur_start;
         prev_size_ff  <= cur_size;
      end
      if (cmd.commit) begin
         res_status_ff  <= res_status_in;
         res_payload_ff <= res_payload_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_payload_ff <= res_payload_ff;
      end
   end

   // Control state: hole count, bump head, capacity, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bump_ff      <= '0;
         cap_ff       <= CAP_W'(ARENA_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
            bump_ff  <= bump_in;
         end
         if (csr_valid) begin
            cap_ff <= csr_data[CAP_W-1:0];
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(16 - ADDR_W){1'b0}}, rsp_payload_ff};

endmodule

FILE: rtl/first_fit_coalescing_arena_allocator_unit.sv
// First-fit coalescing arena allocator: top level.
//
// Requests arrive on req_*: tuser carries the opcode (allocate or free),
// tdata the payload length and the offset to free. Each accepted transfer
// yields exactly one transfer on rsp_*: tuser holds the status, tdata the
// payload offset of a new block (zero unless an allocation succeeded).
// csr_* writes the arena capacity; it is always ready. The capacity must be
// written only while the block is idle; the block itself does not enforce this.
// One request is worked at a time. After acceptance the block size store is
// read, then the first-fit or address-order scan steps over n (0 to 16)
// free-list entries, one per cycle, before the result is committed and
// loaded. req_tready rises again once the result sits in the output register,
// so a stalled receiver holds at most one finished result while the next
// request is being worked.
// Reset empties the free list, sets the bump head to zero and the capacity
// to 4096; the size store is not cleared. A stalled receiver holds the
// result, and the next request then waits before its result is loaded.
module first_fit_coalescing_arena_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] opcode
   input  logic [23:0] req_tdata,   // [11:0] request_length, [23:12] free_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [15:0] rsp_tdata,   // [11:0] payload_offset, [15:12] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [12:0] arena_capacity
);
   import ffca_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   ffca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffca_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/ffca_checker.sv
// Port-level checks for the arena allocator, bound to the top level.
module ffca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [15:0] rsp_tdata
);
   import ffca_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Failed requests return a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == 16'd0)
      else $error("non-zero offset on a failed request");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // A request accepted now blocks acceptance of another in the next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is being worked");

endmodule

bind first_fit_coalescing_arena_allocator_unit ffca_checker u_ffca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
